[rtl/core/tvpi_pkg.sv]
// ----------------------------------------------------------------------------
// tvpi_pkg
// Shared widths and constants for the two-axis velocity PI controller.
// ----------------------------------------------------------------------------
package tvpi_pkg;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LIMIT = 3'd5;

   localparam logic [10:0] NEUTRAL_US = 11'd1500;

endpackage

[rtl/core/two_axis_velocity_pi_controller.sv]
// ----------------------------------------------------------------------------
// two_axis_velocity_pi_controller
// Slew-limited speed ramp and a PI law on two axes that produce roll and
// pitch pulse widths. All products go through one shared 17 x 32 multiplier.
// ----------------------------------------------------------------------------
// The result word is registered and is held back in the output state while an older
// result is still stalled. A new input word is accepted only while idle, after the
// previous word has passed the nine sequential uses of the single shared multiplier
// (fewer when disabled, which skips the integral and drive steps).
// Reset clears the ramp, both integrals and all control state, and loads the
// register defaults.
module two_axis_velocity_pi_controller
   import tvpi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [15:0]      req_dir_x,
   input  logic signed [15:0]      req_dir_y,
   input  logic signed [15:0]      req_target_speed,
   input  logic signed [15:0]      req_vel_x,
   input  logic signed [15:0]      req_vel_y,
   input  logic [15:0]             req_time_step,
   input  logic                    req_target_invalid,
   input  logic                    req_velocity_invalid,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [10:0]             rsp_roll_pulse,
   output logic [10:0]             rsp_pitch_pulse,
   output logic signed [15:0]      rsp_ramped_speed
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_STEP = 4'd1;
   localparam logic [3:0] ST_RAMP = 4'd2;
   localparam logic [3:0] ST_TX   = 4'd3;
   localparam logic [3:0] ST_TY   = 4'd4;
   localparam logic [3:0] ST_PX   = 4'd5;
   localparam logic [3:0] ST_IX   = 4'd6;
   localparam logic [3:0] ST_GX   = 4'd7;
   localparam logic [3:0] ST_PY   = 4'd8;
   localparam logic [3:0] ST_IY   = 4'd9;
   localparam logic [3:0] ST_GY   = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   localparam int ACC_W = 50;

   // Configuration registers.
   logic        enabled_ff;
   logic [15:0] prop_gain_ff;
   logic [15:0] integ_gain_ff;
   logic [15:0] max_accel_ff;
   logic [8:0]  roll_limit_ff;
   logic [8:0]  pitch_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         prop_gain_ff   <= 16'd0;
         integ_gain_ff  <= 16'd0;
         max_accel_ff   <= 16'd256;
         roll_limit_ff  <= 9'd500;
         pitch_limit_ff <= 9'd500;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLED:     enabled_ff     <= csr_wdata[0];
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
            CSR_MAX_ACCEL:   max_accel_ff   <= csr_wdata;
            CSR_ROLL_LIMIT:  roll_limit_ff  <= csr_wdata[8:0];
            CSR_PITCH_LIMIT: pitch_limit_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers.
   logic [3:0]               state_ff, state_in;
   logic signed [15:0]       dx_ff, dx_in;
   logic signed [15:0]       dy_ff, dy_in;
   logic signed [15:0]       tgt_ff, tgt_in;
   logic signed [15:0]       vx_ff, vx_in;
   logic signed [15:0]       vy_ff, vy_in;
   logic [15:0]              dt_ff, dt_in;
   logic                     tinv_ff, tinv_in;
   logic signed [15:0]       ramp_ff, ramp_in;
   logic signed [31:0]       integ_x_ff, integ_x_in;
   logic signed [31:0]       integ_y_ff, integ_y_in;
   logic signed [18:0]       ex_ff, ex_in;
   logic signed [18:0]       ey_ff, ey_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [10:0]              roll_ff, roll_in;
   logic [10:0]              pitch_ff, pitch_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [10:0]              rsp_roll_ff, rsp_roll_in;
   logic [10:0]              rsp_pitch_ff, rsp_pitch_in;
   logic signed [15:0]       rsp_ramp_ff, rsp_ramp_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   logic                     req_take;
   logic                     out_free;
   logic [15:0]              step;
   logic signed [17:0]       ramp_dn;
   logic signed [17:0]       dif;
   logic signed [17:0]       mag;
   logic signed [17:0]       step_s;
   logic signed [18:0]       axis_err;
   logic [8:0]               lim_sel;
   logic signed [ACC_W-1:0]  lim;
   logic signed [ACC_W-1:0]  clamped;
   logic signed [ACC_W-1:0]  clamped_neg;
   logic signed [31:0]       integ_sel;
   logic signed [33:0]       integ_sum;
   logic signed [31:0]       integ_sat;

   tvpi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (state_ff)
         ST_STEP: begin
            mul_a = {1'b0, max_accel_ff};
            mul_b = {16'd0, dt_ff};
         end
         ST_TX: begin
            mul_a = MUL_A_W'(dx_ff);
            mul_b = MUL_B_W'(ramp_ff);
         end
         ST_TY: begin
            mul_a = MUL_A_W'(dy_ff);
            mul_b = MUL_B_W'(ramp_ff);
         end
         ST_PX: begin
            mul_a = {1'b0, prop_gain_ff};
            mul_b = MUL_B_W'(ex_ff);
         end
         ST_IX: begin
            mul_a = {1'b0, integ_gain_ff};
            mul_b = integ_x_ff;
         end
         ST_GX: begin
            mul_a = {1'b0, dt_ff};
            mul_b = MUL_B_W'(ex_ff);
         end
         ST_PY: begin
            mul_a = {1'b0, prop_gain_ff};
            mul_b = MUL_B_W'(ey_ff);
         end
         ST_IY: begin
            mul_a = {1'b0, integ_gain_ff};
            mul_b = integ_y_ff;
         end
         ST_GY: begin
            mul_a = {1'b0, dt_ff};
            mul_b = MUL_B_W'(ey_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Ramp update: the step is the upper half of max_accel times the time step.
   always_comb begin
      step    = prod[31:16];
      step_s  = {2'b00, step};
      ramp_dn = 18'(ramp_ff) - step_s;
      dif     = 18'(tgt_ff) - 18'(ramp_ff);
      mag     = (dif < 0) ? -dif : dif;
   end

   assign axis_err = 19'($signed(prod[31:14]))
                     - ((state_ff == ST_TY) ? 19'(vx_ff) : 19'(vy_ff));

   // Drive clamp and integral saturation, shared by both axes.
   always_comb begin
      lim_sel     = (state_ff == ST_PY) ? roll_limit_ff : pitch_limit_ff;
      lim         = ACC_W'({1'b0, lim_sel, 24'd0});
      if (acc_ff > lim) begin
         clamped = lim;
      end else if (acc_ff < -lim) begin
         clamped = -lim;
      end else begin
         clamped = acc_ff;
      end
      clamped_neg = -clamped;
      integ_sel   = (state_ff == ST_PY) ? integ_x_ff : integ_y_ff;
      integ_sum   = 34'(integ_sel) + prod[41:8];
      if (integ_sum > 34'sh0_7FFF_FFFF) begin
         integ_sat = 32'sh7FFF_FFFF;
      end else if (integ_sum < -34'sh0_8000_0000) begin
         integ_sat = 32'sh8000_0000;
      end else begin
         integ_sat = integ_sum[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      tgt_in       = tgt_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      dt_in        = dt_ff;
      tinv_in      = tinv_ff;
      ramp_in      = ramp_ff;
      integ_x_in   = integ_x_ff;
      integ_y_in   = integ_y_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      acc_in       = acc_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_ramp_in  = rsp_ramp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dx_in    = req_target_invalid ? 16'sd0 : req_dir_x;
               dy_in    = req_target_invalid ? 16'sd0 : req_dir_y;
               tgt_in   = req_target_speed;
               vx_in    = req_velocity_invalid ? 16'sd0 : req_vel_x;
               vy_in    = req_velocity_invalid ? 16'sd0 : req_vel_y;
               dt_in    = req_time_step;
               tinv_in  = req_target_invalid;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            if (tinv_ff) begin
               ramp_in = (ramp_dn < -18'sd32768) ? -16'sd32768 : ramp_dn[15:0];
            end else if (dif >= 0) begin
               ramp_in = (mag < step_s) ? tgt_ff : 16'(18'(ramp_ff) + step_s);
            end else begin
               ramp_in = (mag < step_s) ? tgt_ff : ramp_dn[15:0];
            end
            state_in = ST_TX;
         end
         ST_TX: begin
            state_in = ST_TY;
         end
         ST_TY: begin
            ex_in    = axis_err;
            state_in = ST_PX;
         end
         ST_PX: begin
            ey_in = axis_err;
            if (enabled_ff) begin
               state_in = ST_IX;
            end else begin
               roll_in  = NEUTRAL_US;
               pitch_in = NEUTRAL_US;
               state_in = ST_OUT;
            end
         end
         ST_IX, ST_IY: begin
            acc_in   = ACC_W'(prod) <<< 8;
            state_in = state_ff + 4'd1;
         end
         ST_GX, ST_GY: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = state_ff + 4'd1;
         end
         ST_PY: begin
            roll_in    = NEUTRAL_US + 11'($signed(clamped[33:24]));
            integ_x_in = integ_sat;
            state_in   = ST_IY;
         end
         ST_FIN: begin
            pitch_in   = NEUTRAL_US + 11'($signed(clamped_neg[33:24]));
            integ_y_in = integ_sat;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_roll_in  = roll_ff;
               rsp_pitch_in = pitch_ff;
               rsp_ramp_in  = ramp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ramp_ff      <= 16'sd0;
         integ_x_ff   <= 32'sd0;
         integ_y_ff   <= 32'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ramp_ff      <= ramp_in;
         integ_x_ff   <= integ_x_in;
         integ_y_ff   <= integ_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      tgt_ff       <= tgt_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      dt_ff        <= dt_in;
      tinv_ff      <= tinv_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      acc_ff       <= acc_in;
      roll_ff      <= roll_in;
      pitch_ff     <= pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_ramp_ff  <= rsp_ramp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roll_pulse   = rsp_roll_ff;
   assign rsp_pitch_pulse  = rsp_pitch_ff;
   assign rsp_ramped_speed = rsp_ramp_ff;

endmodule

[rtl/core/tvpi_mul.sv]
// ----------------------------------------------------------------------------
// tvpi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tvpi_mul
   import tvpi_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [MUL_P_W-1:0] prod
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[tb/tb_two_axis_velocity_pi_controller.sv]
// ----------------------------------------------------------------------------
// tb_two_axis_velocity_pi_controller
// Self-checking bench for the two-axis velocity PI controller. A tracker
// class recomputes the speed ramp, both integrals and both pulse widths for
// every accepted tick word and compares each result word field by field.
// A short directed run covers the field extremes, invalid target and
// velocity, ramp saturation, oversized directions and limits, and the
// disabled mode. Eight random phases follow under different register
// settings, with random gaps on the tick side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_two_axis_velocity_pi_controller;
   import tvpi_pkg::*;

   typedef struct {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] target_speed;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [15:0]        time_step;
      logic               target_invalid;
      logic               velocity_invalid;
   } tick_type;

   typedef struct {
      logic [10:0]        roll_pulse;
      logic [10:0]        pitch_pulse;
      logic signed [15:0] ramped_speed;
   } pulse_set_type;

   class pi_tick_tracker_type;
      logic               enabled;
      logic [15:0]        prop_gain;
      logic [15:0]        integ_gain;
      logic [15:0]        max_accel;
      logic [8:0]         roll_limit;
      logic [8:0]         pitch_limit;
      logic signed [15:0] ramp_speed;
      int                 integ_x;
      int                 integ_y;
      pulse_set_type      expected[$];
      int                 mismatches;

      function new();
         enabled     = 1'b0;
         prop_gain   = 16'd0;
         integ_gain  = 16'd0;
         max_accel   = 16'd256;
         roll_limit  = 9'd500;
         pitch_limit = 9'd500;
         ramp_speed  = 16'sd0;
         integ_x     = 0;
         integ_y     = 0;
         mismatches  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENABLED: begin
               enabled = data[0];
            end
            CSR_PROP_GAIN: begin
               prop_gain = data;
            end
            CSR_INTEG_GAIN: begin
               integ_gain = data;
            end
            CSR_MAX_ACCEL: begin
               max_accel = data;
            end
            CSR_ROLL_LIMIT: begin
               roll_limit = data[8:0];
            end
            CSR_PITCH_LIMIT: begin
               pitch_limit = data[8:0];
            end
            default: begin
            end
         endcase
      endfunction

      // The drive uses the integral from before this tick; the integral is
      // advanced afterwards and saturates to the signed 32-bit range.
      function longint axis_drive(longint err, inout int integ, logic [8:0] limit,
                                  logic [15:0] dt);
         longint drive;
         longint lim;
         longint sum;
         drive = longint'(prop_gain) * err * 256 + longint'(integ_gain) * longint'(integ);
         lim = longint'(limit) <<< 24;
         if (drive > lim) drive = lim;
         if (drive < -lim) drive = -lim;
         sum = longint'(integ) + ((longint'(dt) * err) >>> 8);
         if (sum > 64'sd2147483647) sum = 64'sd2147483647;
         if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         integ = int'(sum);
         return drive;
      endfunction

      function void note_tick(tick_type t);
         longint        step;
         longint        ramp;
         longint        diff;
         longint        dx;
         longint        dy;
         longint        vx;
         longint        vy;
         longint        err_x;
         longint        err_y;
         longint        roll_drive;
         longint        pitch_drive;
         pulse_set_type p;
         step = (longint'(max_accel) * longint'(t.time_step)) >>> 16;
         ramp = longint'(ramp_speed);
         if (t.target_invalid) begin
            dx = 0;
            dy = 0;
            ramp = ramp - step;
            if (ramp < -32768) ramp = -32768;
         end else begin
            dx = longint'(t.dir_x);
            dy = longint'(t.dir_y);
            diff = longint'(t.target_speed) - ramp;
            if (diff >= 0) ramp = ramp + ((diff < step) ? diff : step);
            else ramp = ramp - ((-diff < step) ? -diff : step);
         end
         vx = t.velocity_invalid ? 64'sd0 : longint'(t.vel_x);
         vy = t.velocity_invalid ? 64'sd0 : longint'(t.vel_y);
         ramp_speed = ramp[15:0];
         p.roll_pulse   = NEUTRAL_US;
         p.pitch_pulse  = NEUTRAL_US;
         p.ramped_speed = ramp[15:0];
         if (enabled) begin
            err_x = ((dx * ramp) >>> 14) - vx;
            err_y = ((dy * ramp) >>> 14) - vy;
            roll_drive  = axis_drive(err_x, integ_x, roll_limit, t.time_step);
            pitch_drive = axis_drive(err_y, integ_y, pitch_limit, t.time_step);
            p.roll_pulse  = 11'(((longint'(NEUTRAL_US) <<< 24) + roll_drive) >>> 24);
            p.pitch_pulse = 11'(((longint'(NEUTRAL_US) <<< 24) - pitch_drive) >>> 24);
         end
         expected.push_back(p);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("ERROR: %s", what);
      endtask

      task check_pulses(logic [10:0] roll, logic [10:0] pitch, logic signed [15:0] ramp);
         pulse_set_type want;
         if (expected.size() == 0) begin
            report("result word arrived with no tick outstanding");
         end else begin
            want = expected.pop_front();
            if (roll !== want.roll_pulse)
               report($sformatf("roll_pulse got %0d expected %0d", roll, want.roll_pulse));
            if (pitch !== want.pitch_pulse)
               report($sformatf("pitch_pulse got %0d expected %0d", pitch, want.pitch_pulse));
            if (ramp !== want.ramped_speed)
               report($sformatf("ramped_speed got %0d expected %0d", ramp, want.ramped_speed));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ENABLED;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_dir_x = '0;
   logic signed [15:0]    req_dir_y = '0;
   logic signed [15:0]    req_target_speed = '0;
   logic signed [15:0]    req_vel_x = '0;
   logic signed [15:0]    req_vel_y = '0;
   logic [15:0]           req_time_step = '0;
   logic                  req_target_invalid = 1'b0;
   logic                  req_velocity_invalid = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [10:0]           rsp_roll_pulse;
   logic [10:0]           rsp_pitch_pulse;
   logic signed [15:0]    rsp_ramped_speed;

   pi_tick_tracker_type tracker = new();

   int                 send_count = 0;
   bit                 send_quiet = 1'b0;
   int                 sink_count = 0;
   bit                 sink_quiet = 1'b0;
   int                 idle_cycles = 0;
   logic signed [15:0] heading_x = '0;
   logic signed [15:0] heading_y = '0;
   logic signed [15:0] cruise_speed = '0;

   two_axis_velocity_pi_controller dut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_dir_x            (req_dir_x),
      .req_dir_y            (req_dir_y),
      .req_target_speed     (req_target_speed),
      .req_vel_x            (req_vel_x),
      .req_vel_y            (req_vel_y),
      .req_time_step        (req_time_step),
      .req_target_invalid   (req_target_invalid),
      .req_velocity_invalid (req_velocity_invalid),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_roll_pulse       (rsp_roll_pulse),
      .rsp_pitch_pulse      (rsp_pitch_pulse),
      .rsp_ramped_speed     (rsp_ramped_speed)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= 2000) begin
            $display("two_axis_velocity_pi_controller verification failed");
            $finish;
         end
      end
   end

   function automatic tick_type make_tick(int dx, int dy, int spd, int vx, int vy, int dt,
                                          bit tinv, bit vinv);
      tick_type t;
      t.dir_x            = 16'(dx);
      t.dir_y            = 16'(dy);
      t.target_speed     = 16'(spd);
      t.vel_x            = 16'(vx);
      t.vel_y            = 16'(vy);
      t.time_step        = 16'(dt);
      t.target_invalid   = tinv;
      t.velocity_invalid = vinv;
      return t;
   endfunction

   // Half the ticks follow the phase heading and most follow the cruise speed so that errors
   // keep one sign long enough to drive the integrals into saturation.
   function automatic tick_type random_tick();
      tick_type t;
      int       shape;
      shape = $urandom_range(0, 19);
      if (shape < 3) begin
         t = make_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         if (shape < 13) begin
            t.dir_x = heading_x + 16'(int'($urandom_range(0, 128)) - 64);
            t.dir_y = heading_y + 16'(int'($urandom_range(0, 128)) - 64);
         end else begin
            t.dir_x = 16'(int'($urandom_range(0, 32768)) - 16384);
            t.dir_y = 16'(int'($urandom_range(0, 32768)) - 16384);
         end
         t.target_speed = (shape < 15) ? cruise_speed : 16'($urandom);
         t.vel_x = 16'(int'($urandom_range(0, 4096)) - 2048);
         t.vel_y = 16'(int'($urandom_range(0, 4096)) - 2048);
         t.time_step = (shape < 12) ? 16'($urandom) : 16'($urandom_range(0, 2048));
         t.target_invalid   = ($urandom_range(0, 19) == 0);
         t.velocity_invalid = ($urandom_range(0, 19) == 0);
      end
      return t;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 16'h0400));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd500;
         2: return 16'd511;
         default: return 16'($urandom_range(1, 500));
      endcase
   endfunction

   task automatic write_settings(logic [15:0] en, logic [15:0] kp, logic [15:0] ki,
                                 logic [15:0] accel, logic [15:0] roll_lim,
                                 logic [15:0] pitch_lim);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      idx = '{CSR_ENABLED, CSR_PROP_GAIN, CSR_INTEG_GAIN, CSR_MAX_ACCEL,
              CSR_ROLL_LIMIT, CSR_PITCH_LIMIT};
      val = '{en, kp, ki, accel, roll_lim, pitch_lim};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.set_register(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_tick(tick_type t);
      int gap;
      send_count++;
      if (send_count % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      gap = send_quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_dir_x            <= t.dir_x;
      req_dir_y            <= t.dir_y;
      req_target_speed     <= t.target_speed;
      req_vel_x            <= t.vel_x;
      req_vel_y            <= t.vel_y;
      req_time_step        <= t.time_step;
      req_target_invalid   <= t.target_invalid;
      req_velocity_invalid <= t.velocity_invalid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(t);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.expected.size() != 0) @(posedge clock);
   endtask

   // After each accepted result word, a random hold is drawn that stalls the next result word.
   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1) begin
            if (!rsp_stall) begin
               tracker.check_pulses(rsp_roll_pulse, rsp_pitch_pulse, rsp_ramped_speed);
               sink_count++;
               if (sink_count % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
               hold = sink_quiet ? 0 : $urandom_range(0, 3);
            end else if (hold > 0) begin
               hold--;
            end
            rsp_stall <= (hold != 0);
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_settings(16'd1, 16'h0800, 16'h0100, 16'h4000, 16'd511, 16'd500);
      send_tick(make_tick(16384, 0, 16'h0200, 0, 0, 16'h1000, 0, 0));
      send_tick(make_tick(0, -16384, 16'h0200, 16'h0100, -16'sh0100, 16'h1000, 0, 0));
      send_tick(make_tick(32767, -32768, 32767, -32768, 32767, 16'hFFFF, 0, 0));
      send_tick(make_tick(-32768, 32767, -32768, 32767, -32768, 16'hFFFF, 0, 0));
      send_tick(make_tick(-16384, 16384, -32768, 0, 0, 0, 0, 0));
      send_tick(make_tick(16384, 16384, 16'h1000, 32767, -32768, 16'h8000, 0, 1));
      repeat (3) send_tick(make_tick(16384, 16384, 32767, 0, 0, 16'hFFFF, 1, 0));
      send_tick(make_tick(-16384, 16384, 32767, 16'h0400, 16'h0400, 16'h2000, 1, 1));
      send_tick(make_tick(16384, 0, 32767, -32768, 0, 16'hFFFF, 0, 0));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(16384, -16384, -16'sh0100, 32767, 32767, 1, 0, 0));
      send_tick(make_tick(16384, 16384, 0, 16'h0080, 16'h0080, 16'hFFFF, 0, 0));
      drain_results();

      write_settings(16'd0, 16'h0800, 16'h0100, 16'h4000, 16'd511, 16'd500);
      send_tick(make_tick(16384, 0, 16'h0400, 0, 0, 16'h4000, 0, 0));
      send_tick(make_tick(0, 16384, -16'sh0400, 16'h0100, 16'h0100, 16'hFFFF, 1, 0));

      for (int p = 0; p < 8; p++) begin
         drain_results();
         if (p == 0) begin
            write_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd500, 16'd500);
         end else if (p == 1) begin
            write_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
         end else begin
            write_settings(16'(p % 4 != 3), pick_word(), pick_word(), pick_word(),
                           pick_limit(), pick_limit());
         end
         heading_x    = (p < 4) ? 16'sd15000 : -16'sd15000;
         heading_y    = (p < 4) ? -16'sd9000 : 16'sd9000;
         cruise_speed = 16'($urandom);
         repeat (116) send_tick(random_tick());
      end

      drain_results();
      repeat (24) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected.size() == 0) begin
         $display("two_axis_velocity_pi_controller verification clean");
      end else begin
         $display("two_axis_velocity_pi_controller verification failed");
      end
      $finish;
   end

endmodule
